/* hdl/dtp_pkg.sv */
// Shared constants, codes and helper functions for the duration text parser.
`default_nettype none

package dtp_pkg;

	// Fraction of seconds: number of digits read as milliseconds
	localparam int FRACTION_DIGITS = 3;
	localparam int FD_W            = $clog2(FRACTION_DIGITS + 1);
	localparam int FRAC_W          = 10;
	localparam int MSEC_W          = 11;
	localparam int VAL_W           = 32;
	localparam int NUM_COMP        = 6;
	localparam int SLOT_W          = 3;

	// Status codes on the result item
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_PARSE = 2'd1;
	localparam logic [1:0] ST_DESIG = 2'd2;

	// Component slots
	localparam logic [SLOT_W-1:0] SL_YEAR  = 3'd0;
	localparam logic [SLOT_W-1:0] SL_MONTH = 3'd1;
	localparam logic [SLOT_W-1:0] SL_DAY   = 3'd2;
	localparam logic [SLOT_W-1:0] SL_HOUR  = 3'd3;
	localparam logic [SLOT_W-1:0] SL_MIN   = 3'd4;
	localparam logic [SLOT_W-1:0] SL_SEC   = 3'd5;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Y     = 8'h59;

	// Magnitude limit of a number: 2^31
	localparam logic [VAL_W-1:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [VAL_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// acc * 10 + d, saturated at 2^31
	function automatic logic [VAL_W-1:0] add_digit(input logic [VAL_W-1:0] acc,
			input logic [3:0] d);
		logic [VAL_W+3:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VAL_W{1'b0}}, d};
		if (v > {4'h0, MAG_LIMIT}) begin
			return MAG_LIMIT;
		end
		return v[VAL_W-1:0];
	endfunction

	// Component value with the number's own sign and the leading sign folded in
	function automatic logic [VAL_W-1:0] signed_value(input logic [VAL_W-1:0] acc,
			input logic num_neg, input logic tot_neg);
		logic [VAL_W-1:0] sat;
		logic [VAL_W-1:0] mag;
		sat = acc[VAL_W-1] ? POS_MAX : acc;
		mag = num_neg ? acc : sat;
		if (num_neg ^ tot_neg) begin
			return ~mag + 1'b1;
		end
		return sat;
	endfunction

	// Weight of a fraction digit by its position: 100, 10, 1
	function automatic logic [FRAC_W-1:0] digit_weight(input logic [3:0] d,
			input logic [FD_W-1:0] pos);
		logic [FD_W-1:0] e;
		e = FD_W'(FRACTION_DIGITS - 1) - pos;
		case (e)
			2'd0:    return FRAC_W'(d);
			2'd1:    return FRAC_W'(d) * FRAC_W'(10);
			2'd2:    return FRAC_W'(d) * FRAC_W'(100);
			default: return '0;
		endcase
	endfunction

endpackage

`default_nettype wire

/* hdl/duration_text_parser_core.sv */
// Streaming ISO 8601 duration parser: one character per item, one result per string.
//
// Accepts one character item per clock and emits the seven duration components plus a
// status in the cycle after the item flagged last_char is taken. The parse state and the
// signed components live in registers updated by one pass of logic per character; the
// result sits in an output register, and a new character is taken in every cycle in
// which that register is empty or is being drained. Sustained rate: one item per cycle while results are drained.
// Components are kept already signed, so the leading '-' needs no separate step. On a
// parse error (status 1) or a bad designator (status 2) all components read as zero.
`default_nettype none

module duration_text_parser_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         char_code,
	input  wire logic               last_char,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      years,
	output logic signed [31:0]      months,
	output logic signed [31:0]      days,
	output logic signed [31:0]      hours,
	output logic signed [31:0]      minutes,
	output logic signed [31:0]      seconds,
	output logic signed [10:0]      millis,
	output logic [1:0]              status
);

	localparam int VW = dtp_pkg::VAL_W;
	localparam int NC = dtp_pkg::NUM_COMP;

	// Parser phases
	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_SIGN   = 3'd1;
	localparam logic [2:0] PH_ITEM   = 3'd2;
	localparam logic [2:0] PH_SPACE  = 3'd3;
	localparam logic [2:0] PH_NUMSGN = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;
	localparam logic [2:0] PH_FRAC   = 3'd6;
	localparam logic [2:0] PH_HALT   = 3'd7;

	logic [2:0]                     phase_q, phase_d;
	logic                           tot_neg_q, tot_neg_d;
	logic                           time_q, time_d;
	logic [1:0]                     err_q, err_d;
	logic [VW-1:0]                  acc_q, acc_d;
	logic                           num_neg_q, num_neg_d;
	logic [dtp_pkg::FRAC_W-1:0]     frac_q, frac_d;
	logic [dtp_pkg::FD_W-1:0]       fd_q, fd_d;
	logic [VW-1:0]                  comp_q [NC];
	logic [VW-1:0]                  comp_d [NC];
	logic [dtp_pkg::MSEC_W-1:0]     msec_q, msec_d;

	logic [VW-1:0]                  comp_out_q [NC];
	logic [dtp_pkg::MSEC_W-1:0]     msec_out_q;
	logic [1:0]                     status_q;
	logic                           out_valid_q;

	logic                           accept;
	logic [7:0]                     c;
	logic [3:0]                     dval;
	logic                           c_digit, c_space, c_sign;
	logic                           key_ok;
	logic [dtp_pkg::SLOT_W-1:0]     key_slot;
	logic [VW-1:0]                  num_val;
	logic [1:0]                     final_status;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Character classes
	assign c       = char_code;
	assign dval    = 4'(c - dtp_pkg::CH_ZERO);
	assign c_digit = dtp_pkg::is_digit(c);
	assign c_space = dtp_pkg::is_space(c);
	assign c_sign  = (c == dtp_pkg::CH_PLUS) || (c == dtp_pkg::CH_MINUS);
	assign num_val = dtp_pkg::signed_value(acc_q, num_neg_q, tot_neg_q);

	// Designator to slot
	always_comb begin
		key_ok   = 1'b1;
		key_slot = dtp_pkg::SL_YEAR;
		if (time_q) begin
			priority if (c == dtp_pkg::CH_H) key_slot = dtp_pkg::SL_HOUR;
			else if (c == dtp_pkg::CH_M)     key_slot = dtp_pkg::SL_MIN;
			else if (c == dtp_pkg::CH_S)     key_slot = dtp_pkg::SL_SEC;
			else                             key_ok   = 1'b0;
		end else begin
			priority if (c == dtp_pkg::CH_Y) key_slot = dtp_pkg::SL_YEAR;
			else if (c == dtp_pkg::CH_M)     key_slot = dtp_pkg::SL_MONTH;
			else if (c == dtp_pkg::CH_D)     key_slot = dtp_pkg::SL_DAY;
			else                             key_ok   = 1'b0;
		end
	end

	// Next parse state for one character
	always_comb begin
		phase_d   = phase_q;
		tot_neg_d = tot_neg_q;
		time_d    = time_q;
		err_d     = err_q;
		acc_d     = acc_q;
		num_neg_d = num_neg_q;
		frac_d    = frac_q;
		fd_d      = fd_q;
		comp_d    = comp_q;
		msec_d    = msec_q;
		unique case (phase_q)
			PH_START: begin
				priority if (c == dtp_pkg::CH_MINUS) begin
					tot_neg_d = 1'b1;
					phase_d   = PH_SIGN;
				end else if (c == dtp_pkg::CH_PLUS) begin
					phase_d = PH_SIGN;
				end else if (c == dtp_pkg::CH_P) begin
					phase_d = PH_ITEM;
				end else begin
					err_d   = dtp_pkg::ST_PARSE;
					phase_d = PH_HALT;
				end
			end
			PH_SIGN: begin
				if (c == dtp_pkg::CH_P) begin
					phase_d = PH_ITEM;
				end else begin
					err_d   = dtp_pkg::ST_PARSE;
					phase_d = PH_HALT;
				end
			end
			PH_ITEM: begin
				acc_d     = '0;
				num_neg_d = 1'b0;
				priority if (c == dtp_pkg::CH_NUL) begin
					phase_d = PH_HALT;
					err_d   = dtp_pkg::ST_OK;
				end else if (c == dtp_pkg::CH_T) begin
					if (time_q) begin
						err_d   = dtp_pkg::ST_PARSE;
						phase_d = PH_HALT;
					end else begin
						time_d = 1'b1;
					end
				end else if (c_space) begin
					phase_d = PH_SPACE;
				end else if (c_sign) begin
					num_neg_d = (c == dtp_pkg::CH_MINUS);
					phase_d   = PH_NUMSGN;
				end else if (c_digit) begin
					acc_d   = dtp_pkg::add_digit('0, dval);
					phase_d = PH_DIGITS;
				end else begin
					err_d   = dtp_pkg::ST_PARSE;
					phase_d = PH_HALT;
				end
			end
			PH_SPACE: begin
				priority if (c_space) begin
					phase_d = PH_SPACE;
				end else if (c_sign) begin
					num_neg_d = (c == dtp_pkg::CH_MINUS);
					phase_d   = PH_NUMSGN;
				end else if (c_digit) begin
					acc_d   = dtp_pkg::add_digit(acc_q, dval);
					phase_d = PH_DIGITS;
				end else begin
					err_d   = dtp_pkg::ST_PARSE;
					phase_d = PH_HALT;
				end
			end
			PH_NUMSGN: begin
				if (c_digit) begin
					acc_d   = dtp_pkg::add_digit(acc_q, dval);
					phase_d = PH_DIGITS;
				end else begin
					err_d   = dtp_pkg::ST_PARSE;
					phase_d = PH_HALT;
				end
			end
			PH_DIGITS: begin
				priority if (c_digit) begin
					acc_d = dtp_pkg::add_digit(acc_q, dval);
				end else if (c == dtp_pkg::CH_DOT) begin
					frac_d  = '0;
					fd_d    = '0;
					phase_d = PH_FRAC;
				end else if (key_ok) begin
					comp_d[key_slot] = num_val;
					phase_d          = PH_ITEM;
				end else begin
					err_d   = dtp_pkg::ST_DESIG;
					phase_d = PH_HALT;
				end
			end
			PH_FRAC: begin
				priority if (c_digit && (int'(fd_q) < dtp_pkg::FRACTION_DIGITS)) begin
					frac_d = frac_q + dtp_pkg::digit_weight(dval, fd_q);
					fd_d   = fd_q + 1'b1;
				end else if (c == dtp_pkg::CH_S) begin
					// seconds slot even before 'T'
					comp_d[dtp_pkg::SL_SEC] = num_val;
					msec_d = tot_neg_q ? (~{1'b0, frac_q} + 1'b1) : {1'b0, frac_q};
					phase_d = PH_ITEM;
				end else begin
					err_d   = dtp_pkg::ST_PARSE;
					phase_d = PH_HALT;
				end
			end
			default: begin
				// halted: characters ignored until the end of the string
			end
		endcase
	end

	// Status at end of string: the end marker acts as a zero byte
	always_comb begin
		if (phase_d == PH_HALT) begin
			final_status = err_d;
		end else if (phase_d == PH_ITEM) begin
			final_status = dtp_pkg::ST_OK;
		end else if (phase_d == PH_DIGITS) begin
			final_status = dtp_pkg::ST_DESIG;
		end else begin
			final_status = dtp_pkg::ST_PARSE;
		end
	end

	// Parse state registers; cleared after every string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			tot_neg_q <= 1'b0;
			time_q    <= 1'b0;
			err_q     <= dtp_pkg::ST_OK;
			acc_q     <= '0;
			num_neg_q <= 1'b0;
			frac_q    <= '0;
			fd_q      <= '0;
			msec_q    <= '0;
			for (int i = 0; i < NC; i++) begin
				comp_q[i] <= '0;
			end
		end else if (accept) begin
			if (last_char) begin
				phase_q   <= PH_START;
				tot_neg_q <= 1'b0;
				time_q    <= 1'b0;
				err_q     <= dtp_pkg::ST_OK;
				acc_q     <= '0;
				num_neg_q <= 1'b0;
				frac_q    <= '0;
				fd_q      <= '0;
				msec_q    <= '0;
				for (int i = 0; i < NC; i++) begin
					comp_q[i] <= '0;
				end
			end else begin
				phase_q   <= phase_d;
				tot_neg_q <= tot_neg_d;
				time_q    <= time_d;
				err_q     <= err_d;
				acc_q     <= acc_d;
				num_neg_q <= num_neg_d;
				frac_q    <= frac_d;
				fd_q      <= fd_d;
				msec_q    <= msec_d;
				comp_q    <= comp_d;
			end
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_char) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; zero components on any error
	always_ff @(posedge clk) begin
		if (accept && last_char) begin
			status_q <= final_status;
			for (int i = 0; i < NC; i++) begin
				comp_out_q[i] <= (final_status == dtp_pkg::ST_OK) ? comp_d[i] : '0;
			end
			msec_out_q <= (final_status == dtp_pkg::ST_OK) ? msec_d : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign years     = comp_out_q[dtp_pkg::SL_YEAR];
	assign months    = comp_out_q[dtp_pkg::SL_MONTH];
	assign days      = comp_out_q[dtp_pkg::SL_DAY];
	assign hours     = comp_out_q[dtp_pkg::SL_HOUR];
	assign minutes   = comp_out_q[dtp_pkg::SL_MIN];
	assign seconds   = comp_out_q[dtp_pkg::SL_SEC];
	assign millis    = msec_out_q;
	assign status    = status_q;

endmodule

`default_nettype wire
